// File: sv/slfl_pkg.sv
// ---------------------------------------------------------------------------
// slfl_pkg
// shared sizes, status codes and state codes of the typed slot allocator
// ---------------------------------------------------------------------------
`default_nettype none

package slfl_pkg;

   localparam int TYPES     = 19;
   localparam int SLOTS     = 256;

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TYPE_W    = (TYPES > 1) ? $clog2(TYPES) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);
   localparam int RAM_DEPTH = TYPES * (1 << SLOT_W);
   localparam int ADDR_W    = $clog2(RAM_DEPTH);

   localparam int OP_W      = 1;
   localparam int PTYPE_W   = 5;
   localparam int SLOTIO_W  = 8;
   localparam int STATUS_W  = 2;
   localparam int ACTIVE_W  = 9;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_EXHAUSTED    = 2'd1,
      STAT_ALREADY_FREE = 2'd2,
      STAT_BAD_TYPE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

// File: sv/typed_slot_free_list_allocator.sv
// ---------------------------------------------------------------------------
// typed_slot_free_list_allocator
// per-type lifo free lists of slot indices with occupancy tracking
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_op, req_pool_type, req_slot_index
//  rsp     | out       | rsp_valid, rsp_stall | rsp_slot_out, rsp_status, rsp_active_count
//
//  one transaction at a time: ram read at accept, then update and write back
//  of the stack ram and the occupancy ram in the execute state, stalled by rsp_stall
//  reset sets the per-pool counts and low-water marks to SLOTS, no ram sweep
//  a held result under rsp_stall does not block acceptance; completion waits
// ---------------------------------------------------------------------------
`default_nettype none

module typed_slot_free_list_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [slfl_pkg::OP_W-1:0]         req_op,
   input  wire logic [slfl_pkg::PTYPE_W-1:0]      req_pool_type,
   input  wire logic [slfl_pkg::SLOTIO_W-1:0]     req_slot_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [slfl_pkg::SLOTIO_W-1:0]     rsp_slot_out,
   output logic      [slfl_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [slfl_pkg::ACTIVE_W-1:0]     rsp_active_count
);

   import slfl_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff [TYPES];
   logic [CNT_W-1:0] lwm_ff [TYPES];

   logic              rq_op_ff;
   logic              rq_ok_ff;
   logic [TYPE_W-1:0] rq_idx_ff;
   logic [SLOTIO_W-1:0] rq_slot_ff;
   logic [CNT_W-1:0]  rq_cnt_ff;
   logic [CNT_W-1:0]  rq_lwm_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOTIO_W-1:0] rsp_slot_ff, rsp_slot_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ACTIVE_W-1:0] rsp_active_ff, rsp_active_in;

   logic              accept;
   logic              acc_ok;
   logic [TYPE_W-1:0] acc_idx;
   logic [CNT_W-1:0]  acc_cnt;

   logic              fire;
   logic [SLOT_W-1:0] top_pos;
   logic              top_fresh;
   logic [SLOT_W-1:0] got;
   logic              slot_in_range;
   logic [SLOT_W-1:0] rq_slot_w;
   logic              occ_now;

   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_new;
   logic [CNT_W-1:0]  lwm_new;

   logic              stk_we;
   logic [ADDR_W-1:0] stk_waddr;
   logic [ADDR_W-1:0] stk_raddr;
   logic [SLOT_W-1:0] stk_rdata;

   logic              occ_we;
   logic [ADDR_W-1:0] occ_waddr;
   logic              occ_wdata;
   logic [ADDR_W-1:0] occ_raddr;
   logic [0:0]        occ_rdata;

   // accept side
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign acc_ok    = (32'(req_pool_type) < TYPES);
   assign acc_idx   = acc_ok ? req_pool_type[TYPE_W-1:0] : '0;
   assign acc_cnt   = cnt_ff[acc_idx];
   assign stk_raddr = ADDR_W'({acc_idx, SLOT_W'(acc_cnt - CNT_W'(1))});
   assign occ_raddr = ADDR_W'({acc_idx, req_slot_index[SLOT_W-1:0]});

   // execute side
   assign fire          = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign top_pos       = SLOT_W'(rq_cnt_ff - CNT_W'(1));
   assign top_fresh     = (CNT_W'(top_pos) < rq_lwm_ff);
   assign slot_in_range = (32'(rq_slot_ff) < SLOTS);
   assign rq_slot_w     = rq_slot_ff[SLOT_W-1:0];

   always_comb begin
      got = top_fresh ? SLOT_W'(CNT_W'(SLOTS - 1) - CNT_W'(top_pos)) : stk_rdata;
      if (32'(got) >= SLOTS) begin
         got = '0;
      end
      occ_now = slot_in_range && occ_rdata[0]
                && ((CNT_W + 1)'(rq_slot_w) + (CNT_W + 1)'(rq_lwm_ff) < (CNT_W + 1)'(SLOTS));

      cnt_we        = 1'b0;
      cnt_new       = rq_cnt_ff;
      lwm_new       = rq_lwm_ff;
      stk_we        = 1'b0;
      stk_waddr     = ADDR_W'({rq_idx_ff, SLOT_W'(rq_cnt_ff)});
      occ_we        = 1'b0;
      occ_waddr     = ADDR_W'({rq_idx_ff, rq_slot_w});
      occ_wdata     = 1'b0;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_active_in = rsp_active_ff;

      if (fire) begin
         if (!rq_ok_ff) begin
            rsp_slot_in   = '0;
            rsp_status_in = STAT_BAD_TYPE;
            rsp_active_in = '0;
         end else if (rq_op_ff == OP_ALLOC) begin
            if (rq_cnt_ff == '0) begin
               rsp_slot_in   = '0;
               rsp_status_in = STAT_EXHAUSTED;
               rsp_active_in = ACTIVE_W'(SLOTS);
            end else begin
               cnt_we    = fire;
               cnt_new   = rq_cnt_ff - CNT_W'(1);
               if (top_fresh) begin
                  lwm_new = CNT_W'(top_pos);
               end
               occ_we    = fire;
               occ_waddr = ADDR_W'({rq_idx_ff, got});
               occ_wdata = 1'b1;
               rsp_slot_in   = SLOTIO_W'(got);
               rsp_status_in = STAT_OK;
               rsp_active_in = ACTIVE_W'(CNT_W'(SLOTS) - cnt_new);
            end
         end else begin
            if (!occ_now || (32'(rq_cnt_ff) >= SLOTS)) begin
               rsp_slot_in   = rq_slot_ff;
               rsp_status_in = STAT_ALREADY_FREE;
               rsp_active_in = ACTIVE_W'(CNT_W'(SLOTS) - rq_cnt_ff);
            end else begin
               cnt_we    = fire;
               cnt_new   = rq_cnt_ff + CNT_W'(1);
               stk_we    = fire;
               occ_we    = fire;
               occ_wdata = 1'b0;
               rsp_slot_in   = rq_slot_ff;
               rsp_status_in = STAT_OK;
               rsp_active_in = ACTIVE_W'(CNT_W'(SLOTS) - cnt_new);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TYPES; t++) begin
            cnt_ff[t] <= CNT_W'(SLOTS);
            lwm_ff[t] <= CNT_W'(SLOTS);
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            cnt_ff[rq_idx_ff] <= cnt_new;
            lwm_ff[rq_idx_ff] <= lwm_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rq_op_ff   <= req_op[0];
         rq_ok_ff   <= acc_ok;
         rq_idx_ff  <= acc_idx;
         rq_slot_ff <= req_slot_index;
         rq_cnt_ff  <= acc_cnt;
         rq_lwm_ff  <= lwm_ff[acc_idx];
      end
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_active_ff <= rsp_active_in;
   end

   slfl_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (RAM_DEPTH)
   ) u_stack_ram (
      .clock      (clock),
      .wr_en      (stk_we),
      .wr_addr    (stk_waddr),
      .wr_data    (rq_slot_w),
      .rd_en      (accept),
      .rd_addr    (stk_raddr),
      .rd_data_ff (stk_rdata)
   );

   slfl_ram #(
      .WIDTH (1),
      .DEPTH (RAM_DEPTH)
   ) u_occ_ram (
      .clock      (clock),
      .wr_en      (occ_we),
      .wr_addr    (occ_waddr),
      .wr_data    (occ_wdata),
      .rd_en      (accept),
      .rd_addr    (occ_raddr),
      .rd_data_ff (occ_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_out     = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_active_count = rsp_active_ff;

`ifndef SYNTH
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction did not enter execution");

   a_bad_type_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_BAD_TYPE |-> rsp_slot_out == '0 && rsp_active_count == '0)
      else $error("bad type result carries non-zero fields");

   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_active_count) <= SLOTS)
      else $error("active count above pool size");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("completed transaction produced no result");
`endif

endmodule

`default_nettype wire

// File: sv/slfl_ram.sv
// ---------------------------------------------------------------------------
// slfl_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module slfl_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
